/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b at the same edge
`define ASSERT_SAME(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// a implies b at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/ort_pkg.sv */
// Types and constants for the occluder rectangle tracker
`timescale 1ns / 1ps
package ort_pkg;
    localparam int NUM_OCC = 3;
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int AREA_W  = 2 * DIFF_W;
    localparam int IDX_W   = $clog2(NUM_OCC);
    localparam int CNT_W   = $clog2(NUM_OCC + 1);

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_MERGE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        MUL_NEW = 2'd0,
        MUL_V   = 2'd1,
        MUL_W   = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [COORD_W-1:0]  rect_left;
        logic signed [COORD_W-1:0]  rect_top;
        logic signed [COORD_W-1:0]  rect_right;
        logic signed [COORD_W-1:0]  rect_bottom;
    } req_t;

    typedef struct packed {
        logic       covered;
        logic [1:0] held_count;
    } rsp_t;

    typedef struct packed {
        logic             load;
        logic             query;
        logic             clear;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic             na_latch;
        logic             append;
        logic             ext_sel;
        logic             replace;
        logic             sort;
        logic             out_load;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       last_slot;
        logic       out_free;
    } status_t;
endpackage

/* rtl/ort_ctrl.sv */
// Controller state machine for the occluder rectangle tracker
`timescale 1ns / 1ps
module ort_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ort_pkg::status_t status,
    output ort_pkg::cmd_t   cmd
);
    import ort_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DISP    = 10'b00_0000_0010,
        S_AREA_N  = 10'b00_0000_0100,
        S_NA      = 10'b00_0000_1000,
        S_APPEND  = 10'b00_0001_0000,
        S_EXT_V   = 10'b00_0010_0000,
        S_EXT_W   = 10'b00_0100_0000,
        S_EXT_SEL = 10'b00_1000_0000,
        S_REPLACE = 10'b01_0000_0000,
        S_SORT    = 10'b10_0000_0000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_OCC - 1);

    state_t           state_reg, state_next;
    logic             done_reg, done_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    // done_reg marks a finished request waiting for the output register
    assign req_stall = (state_reg != S_IDLE) || done_reg;

    always_comb begin
        state_next = state_reg;
        done_next  = done_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.phase  = phase_reg;
        cmd.mul_sel = MUL_NEW;
        if (done_reg && status.out_free)
        begin
            cmd.out_load = 1'b1;
            done_next    = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !done_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (status.op)
                    OP_QUERY:
                    begin
                        cmd.query  = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_MERGE:  state_next = S_AREA_N;
                    OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_AREA_N:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NEW;
                state_next  = S_NA;
            end
            S_NA:
            begin
                cmd.na_latch = 1'b1;
                idx_next     = '0;
                state_next   = status.full ? S_EXT_V : S_APPEND;
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                phase_next = '0;
                if (status.last_slot)
                    state_next = S_SORT;
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EXT_V:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_V;
                state_next  = S_EXT_W;
            end
            S_EXT_W:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_W;
                state_next  = S_EXT_SEL;
            end
            S_EXT_SEL:
            begin
                cmd.ext_sel = 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = S_REPLACE;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_EXT_V;
                end
            end
            S_REPLACE:
            begin
                cmd.replace = 1'b1;
                phase_next  = '0;
                state_next  = S_SORT;
            end
            S_SORT:
            begin
                cmd.sort = 1'b1;
                if (phase_reg == LAST_IDX)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    phase_next = phase_reg + 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

/* rtl/ort_datapath.sv */
// Datapath: rectangle store, area multiplier, extension select, sort network
`timescale 1ns / 1ps
module ort_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  ort_pkg::req_t    req,
    input  ort_pkg::cmd_t    cmd,
    input  logic             rsp_stall,
    output ort_pkg::status_t status,
    output logic             rsp_valid,
    output ort_pkg::rsp_t    rsp
);
    import ort_pkg::*;

    typedef logic signed [COORD_W-1:0] crd_t;
    typedef logic signed [DIFF_W-1:0]  dif_t;
    typedef logic signed [AREA_W-1:0]  area_t;

    function automatic crd_t smax(input crd_t a, input crd_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic crd_t smin(input crd_t a, input crd_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic dif_t sdiff(input crd_t hi, input crd_t lo);
        return dif_t'(hi) - dif_t'(lo);
    endfunction

    crd_t  occ_l_reg [NUM_OCC];
    crd_t  occ_t_reg [NUM_OCC];
    crd_t  occ_r_reg [NUM_OCC];
    crd_t  occ_b_reg [NUM_OCC];
    area_t area_reg  [NUM_OCC];

    req_t             req_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             cov_reg;
    area_t            prod_reg;
    area_t            av_reg;
    area_t            na_reg;
    area_t            best_a_reg;
    logic [IDX_W-1:0] best_idx_reg;
    crd_t             bl_reg, bt_reg, br_reg, bb_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    crd_t n_l, n_t, n_r, n_b;
    crd_t a_l, a_t, a_r, a_b;
    crd_t c_l, c_t, c_r, c_b;
    crd_t v_t, v_b, w_l, w_r;
    logic hit, pick_v, take;
    dif_t mul_a, mul_b;
    area_t ea;
    logic n_empty, any_in;

    assign n_l = req_reg.rect_left;
    assign n_t = req_reg.rect_top;
    assign n_r = req_reg.rect_right;
    assign n_b = req_reg.rect_bottom;

    // extension of the entry under evaluation
    assign a_l = occ_l_reg[cmd.idx];
    assign a_t = occ_t_reg[cmd.idx];
    assign a_r = occ_r_reg[cmd.idx];
    assign a_b = occ_b_reg[cmd.idx];
    assign c_l = smax(a_l, n_l);
    assign c_t = smax(a_t, n_t);
    assign c_r = smin(a_r, n_r);
    assign c_b = smin(a_b, n_b);
    assign v_t = smin(a_t, n_t);
    assign v_b = smax(a_b, n_b);
    assign w_l = smin(a_l, n_l);
    assign w_r = smax(a_r, n_r);
    assign hit = (c_l < c_r) && (c_t < c_b);

    always_comb begin
        case (cmd.mul_sel)
            MUL_V:
            begin
                mul_a = sdiff(c_r, c_l);
                mul_b = sdiff(v_b, v_t);
            end
            MUL_W:
            begin
                mul_a = sdiff(w_r, w_l);
                mul_b = sdiff(c_b, c_t);
            end
            default:
            begin
                mul_a = sdiff(n_r, n_l);
                mul_b = sdiff(n_b, n_t);
            end
        endcase
    end

    // prod_reg holds the w area during the select step, av_reg the v area
    assign pick_v = av_reg > prod_reg;
    assign ea     = hit ? (pick_v ? av_reg : prod_reg) : '0;
    assign take   = (ea >= na_reg) && (ea > best_a_reg);

    assign n_empty = !((n_l < n_r) && (n_t < n_b));
    always_comb begin
        any_in = 1'b0;
        for (int i = 0; i < NUM_OCC; i++)
        begin
            if ((CNT_W'(i) < cnt_reg)
                && (occ_l_reg[i] < occ_r_reg[i]) && (occ_t_reg[i] < occ_b_reg[i])
                && (occ_l_reg[i] <= n_l) && (occ_t_reg[i] <= n_t)
                && (occ_r_reg[i] >= n_r) && (occ_b_reg[i] >= n_b))
                any_in = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.mul_sel == MUL_W && cmd.mul_en)
            av_reg <= prod_reg;
        if (cmd.na_latch)
        begin
            na_reg       <= prod_reg;
            best_a_reg   <= '0;
            best_idx_reg <= '0;
        end
        if (cmd.ext_sel && take)
        begin
            best_a_reg   <= ea;
            best_idx_reg <= cmd.idx;
            bl_reg <= pick_v ? c_l : w_l;
            bt_reg <= pick_v ? v_t : c_t;
            br_reg <= pick_v ? c_r : w_r;
            bb_reg <= pick_v ? v_b : c_b;
        end
        if (cmd.append)
        begin
            occ_l_reg[cnt_reg[IDX_W-1:0]] <= n_l;
            occ_t_reg[cnt_reg[IDX_W-1:0]] <= n_t;
            occ_r_reg[cnt_reg[IDX_W-1:0]] <= n_r;
            occ_b_reg[cnt_reg[IDX_W-1:0]] <= n_b;
            area_reg[cnt_reg[IDX_W-1:0]]  <= na_reg;
        end
        else if (cmd.replace)
        begin
            if (best_a_reg > 0)
            begin
                occ_l_reg[best_idx_reg] <= bl_reg;
                occ_t_reg[best_idx_reg] <= bt_reg;
                occ_r_reg[best_idx_reg] <= br_reg;
                occ_b_reg[best_idx_reg] <= bb_reg;
                area_reg[best_idx_reg]  <= best_a_reg;
            end
            else if (na_reg > area_reg[NUM_OCC-1])
            begin
                occ_l_reg[NUM_OCC-1] <= n_l;
                occ_t_reg[NUM_OCC-1] <= n_t;
                occ_r_reg[NUM_OCC-1] <= n_r;
                occ_b_reg[NUM_OCC-1] <= n_b;
                area_reg[NUM_OCC-1]  <= na_reg;
            end
        end
        else if (cmd.sort)
        begin
            // odd-even transposition; strict compare keeps equal areas in order
            for (int j = 0; j < NUM_OCC - 1; j++)
            begin
                if ((j[0] == cmd.phase[0]) && (area_reg[j] < area_reg[j+1]))
                begin
                    occ_l_reg[j] <= occ_l_reg[j+1];
                    occ_t_reg[j] <= occ_t_reg[j+1];
                    occ_r_reg[j] <= occ_r_reg[j+1];
                    occ_b_reg[j] <= occ_b_reg[j+1];
                    area_reg[j]  <= area_reg[j+1];
                    occ_l_reg[j+1] <= occ_l_reg[j];
                    occ_t_reg[j+1] <= occ_t_reg[j];
                    occ_r_reg[j+1] <= occ_r_reg[j];
                    occ_b_reg[j+1] <= occ_b_reg[j];
                    area_reg[j+1]  <= area_reg[j];
                end
            end
        end
        if (cmd.out_load)
        begin
            rsp_reg.covered    <= cov_reg;
            rsp_reg.held_count <= 2'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cov_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                cov_reg <= 1'b0;
            else if (cmd.query)
                cov_reg <= n_empty || any_in;
            if (cmd.clear)
                cnt_reg <= '0;
            else if (cmd.append)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.out_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign status.op        = req_reg.op;
    assign status.full      = (cnt_reg == CNT_W'(NUM_OCC));
    assign status.last_slot = (cnt_reg == CNT_W'(NUM_OCC - 1));
    assign status.out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
endmodule

/* rtl/occluder_rect_tracker_core.sv */
// Top level of the occluder rectangle tracker
// Holds up to three occluder rectangles. One request at a time: a query or
// clear raises rsp_valid after the dispatch step, an append after its append
// step (after the 3-phase sort when it fills the set), and a merge into a full
// set after one shared area multiplier steps through v and w extension areas
// for each held rectangle, then a replace and three sort phases. A new request
// is accepted while the previous result still waits on rsp.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module occluder_rect_tracker_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ort_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ort_pkg::rsp_t rsp
);
    import ort_pkg::*;

    cmd_t    cmd;
    status_t status;

    ort_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ort_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && !req_stall, req_stall)
    `ASSERT_SAME(a_rsp_from_busy, clk, rst_n, $rose(rsp_valid), $past(req_stall))
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
endmodule
